// File: rtl/core/mcfe_pkg.sv
package mcfe_pkg;

  // Recognised keys, in priority order: the first one sets the electric
  // level, the other four set the engine level.
  localparam int NUM_KEYS = 5;
  localparam int KEY_TEXT_BITS = 240;
  localparam int KEY_LEN [NUM_KEYS] = '{18, 7, 7, 21, 30};
  localparam logic [KEY_TEXT_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
    KEY_TEXT_BITS'({"electric_motor", "_pwm"}),
    KEY_TEXT_BITS'("ice_pwm"),
    KEY_TEXT_BITS'("ICE_pwm"),
    KEY_TEXT_BITS'({"combustion_engine", "_pwm"}),
    KEY_TEXT_BITS'({"internal_combustion_engine", "_pwm"})
  };

  // Result kinds
  localparam logic [2:0] ACT_LINE   = 3'd0;
  localparam logic [2:0] ACT_NUMBER = 3'd1;
  localparam logic [2:0] ACT_UP     = 3'd2;
  localparam logic [2:0] ACT_DOWN   = 3'd3;
  localparam logic [2:0] ACT_POWER  = 3'd4;

  // Remote control command codes
  localparam int NUM_STAGE_CODES = 9;
  localparam logic [15:0] IR_NUMBER_CODE [NUM_STAGE_CODES] = '{
    16'h000C, 16'h0018, 16'h005E, 16'h0008, 16'h001C,
    16'h005A, 16'h0042, 16'h0052, 16'h004A
  };
  localparam logic [15:0] IR_UP_0    = 16'h0002;
  localparam logic [15:0] IR_UP_1    = 16'h0015;
  localparam logic [15:0] IR_UP_2    = 16'h0040;
  localparam logic [15:0] IR_UP_3    = 16'h0046;
  localparam logic [15:0] IR_UP_4    = 16'h0047;
  localparam logic [15:0] IR_DOWN_0  = 16'h0007;
  localparam logic [15:0] IR_DOWN_1  = 16'h0019;
  localparam logic [15:0] IR_DOWN_2  = 16'h0098;
  localparam logic [15:0] IR_POWER   = 16'h0045;

  localparam logic [3:0] STAGE_MAX = 4'd9;

  typedef struct packed {
    logic       valid;
    logic       e_set;
    logic [7:0] e_val;
    logic       g_set;
    logic [7:0] g_val;
  } ser_commit_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] action;
    logic [3:0] stage;
  } ir_cmd_t;

  // Character of key k at position pos; zero past the end of the key.
  function automatic logic [7:0] key_char(input int k, input logic [4:0] pos);
    int idx;
    idx = KEY_LEN[k] - 1 - int'(pos);
    if (idx < 0) begin
      key_char = 8'h00;
    end else begin
      key_char = KEY_TEXT[k][idx*8 +: 8];
    end
  endfunction

  // Electric pwm level for each stage.
  function automatic logic [7:0] stage_level(input logic [3:0] st);
    case (st)
      4'd0:    stage_level = 8'd0;
      4'd1:    stage_level = 8'd28;
      4'd2:    stage_level = 8'd57;
      4'd3:    stage_level = 8'd85;
      4'd4:    stage_level = 8'd113;
      4'd5:    stage_level = 8'd142;
      4'd6:    stage_level = 8'd170;
      4'd7:    stage_level = 8'd198;
      4'd8:    stage_level = 8'd227;
      default: stage_level = 8'd255;
    endcase
  endfunction

endpackage

// File: rtl/core/mcfe_ir_decoder.sv
module mcfe_ir_decoder
  import mcfe_pkg::*;
(
  input  logic [15:0] code,
  input  logic [3:0]  stage_in,
  output ir_cmd_t     cmd
);

  logic       num_hit;
  logic [3:0] num_stage;

  always_comb begin
    num_hit   = 1'b0;
    num_stage = 4'd0;
    for (int i = 0; i < NUM_STAGE_CODES; i++) begin
      if (code == IR_NUMBER_CODE[i]) begin
        num_hit   = 1'b1;
        num_stage = 4'(i + 1);
      end
    end
  end

  always_comb begin
    cmd = '0;
    if (num_hit) begin
      cmd.hit    = 1'b1;
      cmd.action = ACT_NUMBER;
      cmd.stage  = num_stage;
    end else if (code == IR_UP_0 || code == IR_UP_1 || code == IR_UP_2 ||
                 code == IR_UP_3 || code == IR_UP_4) begin
      cmd.hit    = 1'b1;
      cmd.action = ACT_UP;
      cmd.stage  = (stage_in >= STAGE_MAX) ? STAGE_MAX : stage_in + 4'd1;
    end else if (code == IR_DOWN_0 || code == IR_DOWN_1 || code == IR_DOWN_2) begin
      cmd.hit    = 1'b1;
      cmd.action = ACT_DOWN;
      if (stage_in == 4'd0) begin
        cmd.stage = 4'd0;
      end else if (stage_in > STAGE_MAX) begin
        cmd.stage = STAGE_MAX;
      end else begin
        cmd.stage = stage_in - 4'd1;
      end
    end else if (code == IR_POWER) begin
      cmd.hit    = 1'b1;
      cmd.action = ACT_POWER;
      cmd.stage  = 4'd0;
    end
  end

endmodule

// File: rtl/core/mcfe_serial_parser.sv
module mcfe_serial_parser
  import mcfe_pkg::*;
#(
  parameter int LINE_MAX = 96
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  output ser_commit_t commit
);

  localparam int CW = $clog2(LINE_MAX);
  localparam logic [CW-1:0] COUNT_LIMIT = CW'(LINE_MAX - 1);

  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;

  localparam int VF_SIGN  = 0;
  localparam int VF_DIGIT = 1;
  localparam int VF_NEG   = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  logic [CW-1:0] count_r, count_nxt;
  logic          overflowed_r, overflowed_nxt;
  logic          terminated_r, terminated_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [4:0]    live_r, live_nxt;
  logic [4:0]    pos_r, pos_nxt;
  logic [7:0]    accum_r, accum_nxt;
  logic [2:0]    flags_r, flags_nxt;
  logic [7:0]    pend_e_r, pend_e_nxt;
  logic [7:0]    pend_g_r, pend_g_nxt;
  logic          pend_e_set_r, pend_e_set_nxt;
  logic          pend_g_set_r, pend_g_set_nxt;
  logic          any_valid_r, any_valid_nxt;

  logic          fin_e, fin_g;
  logic [7:0]    fin_val;
  logic [4:0]    live_eq, live_chr;
  logic [11:0]   dsum;
  logic [7:0]    dsat;
  logic          is_ws;
  logic          fin_now_e, fin_now_g;

  // Outcome of closing the current pair.
  always_comb begin
    fin_val = flags_r[VF_NEG] ? 8'd0 : accum_r;
    fin_e   = (phase_r == PH_VALUE) && flags_r[VF_DIGIT] && live_r[0];
    fin_g   = (phase_r == PH_VALUE) && flags_r[VF_DIGIT] && !live_r[0] && (|live_r[4:1]);
  end

  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      live_eq[i]  = live_r[i] && (KEY_LEN[i] == int'(pos_r));
      live_chr[i] = live_r[i] && (int'(pos_r) < KEY_LEN[i]) &&
                    (key_char(i, pos_r) == rx_byte);
    end
  end

  // Decimal accumulate with saturation at 255.
  always_comb begin
    dsum = 12'(accum_r) * 12'd10 + {8'd0, rx_byte[3:0]};
    dsat = (dsum > 12'd255) ? 8'd255 : dsum[7:0];
  end

  assign is_ws = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign fin_now_e = !terminated_r && fin_e;
  assign fin_now_g = !terminated_r && fin_g;

  always_comb begin
    count_nxt      = count_r;
    overflowed_nxt = overflowed_r;
    terminated_nxt = terminated_r;
    phase_nxt      = phase_r;
    live_nxt       = live_r;
    pos_nxt        = pos_r;
    accum_nxt      = accum_r;
    flags_nxt      = flags_r;
    pend_e_nxt     = pend_e_r;
    pend_g_nxt     = pend_g_r;
    pend_e_set_nxt = pend_e_set_r;
    pend_g_set_nxt = pend_g_set_r;
    any_valid_nxt  = any_valid_r;
    commit         = '0;

    if (fire) begin
      if (rx_byte == CH_LF) begin
        commit.valid = !overflowed_r && (any_valid_r || fin_now_e || fin_now_g);
        commit.e_set = pend_e_set_r || fin_now_e;
        commit.e_val = fin_now_e ? fin_val : pend_e_r;
        commit.g_set = pend_g_set_r || fin_now_g;
        commit.g_val = fin_now_g ? fin_val : pend_g_r;
        count_nxt      = '0;
        overflowed_nxt = 1'b0;
        terminated_nxt = 1'b0;
        any_valid_nxt  = 1'b0;
        pend_e_set_nxt = 1'b0;
        pend_g_set_nxt = 1'b0;
        pend_e_nxt     = 8'd0;
        pend_g_nxt     = 8'd0;
        phase_nxt      = PH_KEY;
        live_nxt       = '1;
        pos_nxt        = '0;
        accum_nxt      = '0;
        flags_nxt      = '0;
      end else if (is_ws) begin
        // Whitespace is dropped without counting.
      end else if (count_r < COUNT_LIMIT) begin
        count_nxt = count_r + CW'(1);
        if (!terminated_r) begin
          if (rx_byte == CH_NUL || rx_byte == CH_COMMA) begin
            if (fin_e) begin
              pend_e_nxt     = fin_val;
              pend_e_set_nxt = 1'b1;
              any_valid_nxt  = 1'b1;
            end
            if (fin_g) begin
              pend_g_nxt     = fin_val;
              pend_g_set_nxt = 1'b1;
              any_valid_nxt  = 1'b1;
            end
            phase_nxt = PH_KEY;
            live_nxt  = '1;
            pos_nxt   = '0;
            accum_nxt = '0;
            flags_nxt = '0;
            if (rx_byte == CH_NUL) begin
              terminated_nxt = 1'b1;
            end
          end else begin
            unique case (phase_r)
              PH_KEY: begin
                if (rx_byte == CH_EQ) begin
                  live_nxt  = live_eq;
                  phase_nxt = PH_VALUE;
                end else begin
                  live_nxt = live_chr;
                  if (pos_r != 5'd31) begin
                    pos_nxt = pos_r + 5'd1;
                  end
                end
              end
              PH_VALUE: begin
                if ((rx_byte == CH_PLUS || rx_byte == CH_MINUS) && flags_r == 3'd0) begin
                  flags_nxt[VF_SIGN] = 1'b1;
                  flags_nxt[VF_NEG]  = (rx_byte == CH_MINUS);
                end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
                  accum_nxt           = dsat;
                  flags_nxt[VF_DIGIT] = 1'b1;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end else begin
        overflowed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      overflowed_r <= 1'b0;
      terminated_r <= 1'b0;
      phase_r      <= PH_KEY;
      live_r       <= '1;
      pos_r        <= '0;
      accum_r      <= '0;
      flags_r      <= '0;
      pend_e_set_r <= 1'b0;
      pend_g_set_r <= 1'b0;
      any_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      overflowed_r <= overflowed_nxt;
      terminated_r <= terminated_nxt;
      phase_r      <= phase_nxt;
      live_r       <= live_nxt;
      pos_r        <= pos_nxt;
      accum_r      <= accum_nxt;
      flags_r      <= flags_nxt;
      pend_e_set_r <= pend_e_set_nxt;
      pend_g_set_r <= pend_g_set_nxt;
      any_valid_r  <= any_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_e_r <= pend_e_nxt;
    pend_g_r <= pend_g_nxt;
  end

endmodule

// File: rtl/core/motor_command_front_end_top.sv
// Path: an accepted item passes the input register and then the result register,
// where any result that it gives is valid on the output.
// Throughput: one item per cycle; the input register and the result register are
// each emptied in the cycle they are read, so a stalled output holds back only the
// input register once a result is waiting.
// Reset: synchronous, active low; levels, stage, line state and configuration clear.
module motor_command_front_end_top
  import mcfe_pkg::*;
#(
  parameter int LINE_MAX = 96
)
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] data
  input  logic        in_tuser,   // [0] func

  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] electric_pwm, [15:8] engine_pwm, [23:16] electric_drive,
  // [31:24] engine_drive, [35:32] stage, [36] changed, [39:37] zero
  output logic [39:0] out_tdata,
  output logic [2:0]  out_tuser,  // [2:0] action

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers. Register 0 (byte address 0) inverts the electric
  // drive, register 1 (byte address 4) inverts the engine drive.
  logic elec_inv_r, eng_inv_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elec_inv_r <= 1'b0;
      eng_inv_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        eng_inv_r <= cfg_pwdata[0];
      end else begin
        elec_inv_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_prdata = {31'd0, cfg_paddr[2] ? eng_inv_r : elec_inv_r};

  // Input register. An item waits here and is processed as soon
  // as the result register can take whatever the item produces.
  logic        in_vld_r;
  logic [15:0] in_data_r;
  logic        in_func_r;
  logic        out_ok;
  logic        go;
  logic        in_acc;

  assign out_ok    = !out_tvalid || out_tready;
  assign go        = in_vld_r && out_ok;
  assign in_tready = !in_vld_r || out_ok;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_tdata;
      in_func_r <= in_tuser;
    end
  end

  // Serial line parser and remote command decoder.
  ser_commit_t ser_commit;
  ir_cmd_t     ir_cmd;
  logic [3:0]  stage_r, stage_nxt;
  logic [7:0]  elec_lvl_r, elec_lvl_nxt;
  logic [7:0]  eng_lvl_r, eng_lvl_nxt;

  mcfe_serial_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (go && !in_func_r),
    .rx_byte (in_data_r[7:0]),
    .commit  (ser_commit)
  );

  mcfe_ir_decoder u_ir (
    .code     (in_data_r),
    .stage_in (stage_r),
    .cmd      (ir_cmd)
  );

  // New levels and the result for the item in the input register.
  logic       res_valid;
  logic [2:0] res_action;

  always_comb begin
    stage_nxt    = stage_r;
    elec_lvl_nxt = elec_lvl_r;
    eng_lvl_nxt  = eng_lvl_r;
    res_valid    = 1'b0;
    res_action   = ACT_LINE;
    if (go) begin
      if (in_func_r) begin
        if (ir_cmd.hit) begin
          res_valid    = 1'b1;
          res_action   = ir_cmd.action;
          stage_nxt    = ir_cmd.stage;
          elec_lvl_nxt = stage_level(ir_cmd.stage);
        end
      end else if (ser_commit.valid) begin
        res_valid = 1'b1;
        if (ser_commit.e_set) begin
          elec_lvl_nxt = ser_commit.e_val;
        end
        if (ser_commit.g_set) begin
          eng_lvl_nxt = ser_commit.g_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= 4'd0;
      elec_lvl_r <= 8'd0;
      eng_lvl_r  <= 8'd0;
    end else begin
      stage_r    <= stage_nxt;
      elec_lvl_r <= elec_lvl_nxt;
      eng_lvl_r  <= eng_lvl_nxt;
    end
  end

  // Result register.
  logic       out_vld_r;
  logic [2:0] out_action_r;
  logic [7:0] out_epwm_r, out_gpwm_r, out_edrv_r, out_gdrv_r;
  logic [3:0] out_stage_r;
  logic       out_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_action_r  <= res_action;
      out_epwm_r    <= elec_lvl_nxt;
      out_gpwm_r    <= eng_lvl_nxt;
      out_edrv_r    <= elec_inv_r ? ~elec_lvl_nxt : elec_lvl_nxt;
      out_gdrv_r    <= eng_inv_r ? ~eng_lvl_nxt : eng_lvl_nxt;
      out_stage_r   <= stage_nxt;
      out_changed_r <= (elec_lvl_nxt != elec_lvl_r) || (eng_lvl_nxt != eng_lvl_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_action_r;
  assign out_tdata  = {3'd0, out_changed_r, out_stage_r, out_gdrv_r, out_edrv_r,
                       out_gpwm_r, out_epwm_r};

`ifndef SYNTHESIS
  // The remote control path never leaves the stage range.
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= STAGE_MAX)
    else $error("stage register out of range");

  // An item in the input register that cannot be processed stays there.
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !go |=> in_vld_r)
    else $error("pending item dropped");

  // A remote control result always reports the table level of its stage.
  a_ir_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_action_r != ACT_LINE) |-> out_epwm_r == stage_level(out_stage_r))
    else $error("remote control level does not match stage");
`endif

endmodule

// File: test/tb_motor_command_front_end_top.sv
module tb_motor_command_front_end_top;
  import mcfe_pkg::*;

  // The block is built with its usual line length. A line may keep LINE_LIMIT-1 bytes.
  localparam int LINE_LIMIT = 96;
  localparam int KEPT_MAX = LINE_LIMIT - 1;

  // An item passes two registers before its result appears. The settling pause gives
  // items that cause no result time to leave the pipeline before a register write or
  // the end of the run.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 115;
  localparam int NUM_PHASES = 4;

  // Register addresses on the configuration port.
  localparam logic [2:0] REG_ELECTRIC_INV = 3'd0;
  localparam logic [2:0] REG_ENGINE_INV = 3'd4;

  // Characters with a meaning to the line parser.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] BLANKS [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

  localparam logic [4:0] ALL_KEYS = 5'h1F;

  localparam logic [15:0] IR_UP_CODES [5] = '{IR_UP_0, IR_UP_1, IR_UP_2, IR_UP_3, IR_UP_4};
  localparam logic [15:0] IR_DOWN_CODES [3] = '{IR_DOWN_0, IR_DOWN_1, IR_DOWN_2};

  // Electric duty for each remote control stage.
  localparam logic [7:0] STAGE_DUTY [10] = '{
    8'd0, 8'd28, 8'd57, 8'd85, 8'd113, 8'd142, 8'd170, 8'd198, 8'd227, 8'd255
  };

  typedef enum logic [1:0] {PAIR_KEY, PAIR_VALUE, PAIR_SKIP} pair_phase_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] electric_pwm;
    logic [7:0] engine_pwm;
    logic [7:0] electric_drive;
    logic [7:0] engine_drive;
    logic [3:0] stage;
    logic       changed;
  } report_t;

  // One row of the directed script: either one remote code or a whole serial line.
  // Rows marked as typed carry the report that their last item must give.
  typedef struct {
    bit          is_ir;
    logic [15:0] code;
    string       text;
    logic [7:0]  hi;
    bit          typed;
    bit          yields;
    logic [2:0]  action;
    logic [7:0]  electric_pwm;
    logic [7:0]  engine_pwm;
    logic [3:0]  stage;
    bit          changed;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] data
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] electric_pwm, [15:8] engine_pwm, [23:16] electric_drive,
  // [31:24] engine_drive, [35:32] stage, [36] changed, [39:37] zero
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;       // [2:0] action
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  motor_command_front_end_top #(.LINE_MAX(LINE_LIMIT)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // The five keys, filled in at the start of the run.
  string known_keys [NUM_KEYS];

  // The directed script. The remote rows walk the stage through both clamps,
  // the first serial line saturates its value and carries junk in the high byte.
  script_row_t script [9] = '{
    '{1'b1, 16'hFFFF, "", 8'h00, 1'b1, 1'b0, ACT_LINE, 8'd0, 8'd0, 4'd0, 1'b0},
    '{1'b1, IR_POWER, "", 8'h00, 1'b1, 1'b1, ACT_POWER, 8'd0, 8'd0, 4'd0, 1'b0},
    '{1'b1, IR_NUMBER_CODE[8], "", 8'h00, 1'b1, 1'b1, ACT_NUMBER, 8'd255, 8'd0, 4'd9, 1'b1},
    '{1'b1, IR_UP_4, "", 8'h00, 1'b1, 1'b1, ACT_UP, 8'd255, 8'd0, 4'd9, 1'b0},
    '{1'b1, IR_NUMBER_CODE[0], "", 8'h00, 1'b1, 1'b1, ACT_NUMBER, 8'd28, 8'd0, 4'd1, 1'b1},
    '{1'b1, IR_DOWN_1, "", 8'h00, 1'b1, 1'b1, ACT_DOWN, 8'd0, 8'd0, 4'd0, 1'b1},
    '{1'b1, IR_DOWN_0, "", 8'h00, 1'b1, 1'b1, ACT_DOWN, 8'd0, 8'd0, 4'd0, 1'b0},
    '{1'b0, 16'h0000, "ice_pwm=300\n", 8'hA5, 1'b1, 1'b1, ACT_LINE, 8'd0, 8'd255, 4'd0, 1'b1},
    '{1'b0, 16'h0000, "ICE_pwm=-7\n", 8'h00, 1'b0, 1'b0, ACT_LINE, 8'd0, 8'd0, 4'd0, 1'b0}
  };

  // Predictor state: our own copy of the configuration, the line parser and the levels.
  bit          inv_electric, inv_engine;
  int          line_len;
  bit          line_over, line_done;
  pair_phase_e phase;
  logic [4:0]  live_keys;
  int          key_pos, val_acc;
  bit          val_sign, val_digit, val_neg;
  logic [7:0]  pend_electric, pend_engine;
  bit          pend_electric_set, pend_engine_set, any_pair;
  logic [7:0]  level_electric, level_engine;
  logic [3:0]  stage_q;

  report_t     awaited_reports [$];
  logic [7:0]  line_bytes [$];
  int          errors = 0;
  int          items_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  report_t     seen, want;

  function automatic string with_pwm(string stem);
    return {stem, "_pwm"};
  endfunction

  function automatic logic [7:0] drive_of(logic [7:0] level, bit inverted);
    return inverted ? 8'd255 - level : level;
  endfunction

  function automatic report_t make_report(logic [2:0] act, bit changed);
    report_t r;
    r.action = act;
    r.electric_pwm = level_electric;
    r.engine_pwm = level_engine;
    r.electric_drive = drive_of(level_electric, inv_electric);
    r.engine_drive = drive_of(level_engine, inv_engine);
    r.stage = stage_q;
    r.changed = changed;
    return r;
  endfunction

  function automatic void open_pair();
    phase = PAIR_KEY;
    live_keys = ALL_KEYS;
    key_pos = 0;
    val_acc = 0;
    val_sign = 1'b0;
    val_digit = 1'b0;
    val_neg = 1'b0;
  endfunction

  // A pair counts only if it reached its value with at least one digit and its key
  // matched exactly. The first key sets the electric level, the rest the engine.
  function automatic void close_pair();
    logic [7:0] v;
    if (phase == PAIR_VALUE && val_digit) begin
      v = val_neg ? 8'd0 : val_acc[7:0];
      if (live_keys[0]) begin
        pend_electric = v;
        pend_electric_set = 1'b1;
        any_pair = 1'b1;
      end else if (live_keys[4:1] != '0) begin
        pend_engine = v;
        pend_engine_set = 1'b1;
        any_pair = 1'b1;
      end
    end
    open_pair();
  endfunction

  function automatic void clear_line();
    line_len = 0;
    line_over = 1'b0;
    line_done = 1'b0;
    any_pair = 1'b0;
    pend_electric_set = 1'b0;
    pend_engine_set = 1'b0;
    pend_electric = '0;
    pend_engine = '0;
    open_pair();
  endfunction

  function automatic void parse_char(logic [7:0] c);
    int i;
    if (c == CH_COMMA) begin
      close_pair();
      return;
    end
    case (phase)
      PAIR_KEY: begin
        if (c == CH_EQUALS) begin
          for (i = 0; i < NUM_KEYS; i++)
            if (known_keys[i].len() != key_pos) live_keys[i] = 1'b0;
          phase = PAIR_VALUE;
        end else begin
          for (i = 0; i < NUM_KEYS; i++)
            if (live_keys[i] && !(key_pos < known_keys[i].len() && known_keys[i][key_pos] == c))
              live_keys[i] = 1'b0;
          if (key_pos < 31) key_pos++;
        end
      end
      PAIR_VALUE: begin
        if ((c == CH_PLUS || c == CH_MINUS) && !val_sign && !val_digit && !val_neg) begin
          val_sign = 1'b1;
          val_neg = (c == CH_MINUS);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          val_acc = val_acc * 10 + int'(c - CH_ZERO);
          if (val_acc > 255) val_acc = 255;
          val_digit = 1'b1;
        end else begin
          phase = PAIR_SKIP;
        end
      end
      default: ;
    endcase
  endfunction

  // Works out what one accepted item does to the block and the report it gives.
  function automatic void decode_item(input bit is_ir, input logic [15:0] d,
                                      output bit yields, output report_t rep);
    logic [7:0] c, ne, ng, prior_level;
    logic [2:0] act;
    logic [3:0] st;
    bit         hit;
    yields = 1'b0;
    rep = '0;
    if (is_ir) begin
      hit = 1'b0;
      act = ACT_LINE;
      st = stage_q;
      prior_level = level_electric;
      for (int i = 0; i < NUM_STAGE_CODES; i++)
        if (d == IR_NUMBER_CODE[i]) begin
          hit = 1'b1;
          act = ACT_NUMBER;
          st = 4'(i + 1);
        end
      foreach (IR_UP_CODES[j])
        if (!hit && d == IR_UP_CODES[j]) begin
          hit = 1'b1;
          act = ACT_UP;
          st = (stage_q >= STAGE_MAX) ? STAGE_MAX : stage_q + 4'd1;
        end
      foreach (IR_DOWN_CODES[j])
        if (!hit && d == IR_DOWN_CODES[j]) begin
          hit = 1'b1;
          act = ACT_DOWN;
          st = (stage_q == 4'd0) ? 4'd0 : ((stage_q > STAGE_MAX) ? STAGE_MAX : stage_q - 4'd1);
        end
      if (!hit && d == IR_POWER) begin
        hit = 1'b1;
        act = ACT_POWER;
        st = 4'd0;
      end
      if (hit) begin
        if (st > STAGE_MAX) st = STAGE_MAX;
        stage_q = st;
        level_electric = STAGE_DUTY[st];
        rep = make_report(act, level_electric != prior_level);
        yields = 1'b1;
      end
    end else begin
      c = d[7:0];
      if (c == CH_LF) begin
        if (!line_over) begin
          if (!line_done) close_pair();
          if (any_pair) begin
            ne = pend_electric_set ? pend_electric : level_electric;
            ng = pend_engine_set ? pend_engine : level_engine;
            hit = (ne != level_electric) || (ng != level_engine);
            level_electric = ne;
            level_engine = ng;
            rep = make_report(ACT_LINE, hit);
            yields = 1'b1;
          end
        end
        clear_line();
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        // Blanks are dropped before they reach the line buffer.
      end else if (line_len < KEPT_MAX) begin
        line_len++;
        if (!line_done) begin
          if (c == CH_NUL) begin
            close_pair();
            line_done = 1'b1;
          end else begin
            parse_char(c);
          end
        end
      end else begin
        line_over = 1'b1;
      end
    end
  endfunction

  function automatic void compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Offers one item, holding it until the block takes it, then runs the predictor.
  // The sender may idle for a while first; valid is only lowered in a step in which
  // it is not raised again.
  task automatic offer(input bit is_ir, input logic [15:0] d,
                       output bit yields, output report_t rep);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_ir;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_item(is_ir, d, yields, rep);
    items_sent++;
  endtask

  task automatic offer_checked(input bit is_ir, input logic [15:0] d);
    bit      y;
    report_t r;
    offer(is_ir, d, y, r);
    if (y) awaited_reports.push_back(r);
  endtask

  task automatic send_serial(input logic [7:0] c);
    logic [7:0] hi;
    hi = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
    offer_checked(1'b0, {hi, c});
  endtask

  // A random remote code, weighted towards the known ones; the down codes get two
  // slots so that the stage often sits at its lower clamp.
  function automatic logic [15:0] ir_pick();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return IR_NUMBER_CODE[$urandom_range(0, NUM_STAGE_CODES - 1)];
      4, 5:       return IR_UP_CODES[$urandom_range(0, 4)];
      6, 7:       return IR_DOWN_CODES[$urandom_range(0, 2)];
      8:          return IR_POWER;
      default:    return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void add_char(logic [7:0] c, bit loose);
    if (loose && $urandom_range(0, 9) == 0) line_bytes.push_back(BLANKS[$urandom_range(0, 4)]);
    line_bytes.push_back(c);
  endfunction

  function automatic void add_text(string s, bit loose);
    for (int k = 0; k < s.len(); k++) add_char(s[k], loose);
  endfunction

  // Builds a mostly well-formed line: one to three pairs with real keys, now and then
  // a key that is one character off, a missing '=', a doubled sign, no digits, junk
  // after the value, empty pairs, stray blanks or a NUL that cuts the line short.
  function automatic void compose_line();
    string key;
    int    m, nd;
    line_bytes.delete();
    for (int p = 0; p < $urandom_range(1, 3); p++) begin
      if (p > 0) add_char(CH_COMMA, 1'b1);
      if ($urandom_range(0, 7) == 0) add_char(CH_COMMA, 1'b1);
      key = known_keys[$urandom_range(0, NUM_KEYS - 1)];
      m = $urandom_range(0, 11);
      if (m == 0) key = key.substr(0, key.len() - 2);
      else if (m == 1) key = {key, "x"};
      else if (m == 2) key = "Ice_pwm";
      add_text(key, 1'b1);
      if ($urandom_range(0, 15) != 0) add_char(CH_EQUALS, 1'b1);
      m = $urandom_range(0, 7);
      if (m == 0 || m == 2) add_char(CH_PLUS, 1'b1);
      if (m == 1 || m == 2) add_char(CH_MINUS, 1'b1);
      nd = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
      repeat (nd) add_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
      if ($urandom_range(0, 11) == 0) add_char(8'($urandom_range(33, 126)), 1'b1);
    end
    if ($urandom_range(0, 9) == 0) begin
      add_char(CH_NUL, 1'b0);
      add_text(",ice_pwm=7", 1'b0);
    end
    line_bytes.push_back(CH_LF);
  endfunction

  // A line of exactly the given number of kept bytes, padded out with empty pairs.
  function automatic void compose_long(int kept);
    line_bytes.delete();
    add_text($sformatf("%s=%0d", known_keys[0], $urandom_range(0, 255)), 1'b0);
    while (line_bytes.size() < kept) line_bytes.push_back(CH_COMMA);
    line_bytes.push_back(CH_LF);
  endfunction

  // Remote codes are slipped in between the bytes now and then; they must leave the
  // partial line alone.
  task automatic send_line();
    foreach (line_bytes[k]) begin
      if ($urandom_range(0, 24) == 0) offer_checked(1'b1, ir_pick());
      send_serial(line_bytes[k]);
    end
  endtask

  // Lowers valid, waits for every awaited report and then for the pipeline to empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A register write: a setup cycle, then an access cycle held until pready. The
  // bus is left idle after each write so that back-to-back writes never meet in a step.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_ELECTRIC_INV) inv_electric = value[0];
    if (addr == REG_ENGINE_INV) inv_engine = value[0];
    @(posedge clk);
  endtask

  // The receiver. A request from the stimulus starts a long hold-off, counted here,
  // during which the block fills up and must stall its input; otherwise ready is
  // dropped at random at the rate of the current phase.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_ack <= hold_req;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Every report taken from the block is checked against the oldest one awaited.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.action = out_tuser;
      seen.electric_pwm = out_tdata[7:0];
      seen.engine_pwm = out_tdata[15:8];
      seen.electric_drive = out_tdata[23:16];
      seen.engine_drive = out_tdata[31:24];
      seen.stage = out_tdata[35:32];
      seen.changed = out_tdata[36];
      if (awaited_reports.size() == 0) begin
        $display("%0t: report expected none, got action %0d electric_pwm %0d engine_pwm %0d",
                 $time, seen.action, seen.electric_pwm, seen.engine_pwm);
        errors++;
      end else begin
        want = awaited_reports.pop_front();
        compare_field("action", want.action, seen.action);
        compare_field("electric_pwm", want.electric_pwm, seen.electric_pwm);
        compare_field("engine_pwm", want.engine_pwm, seen.engine_pwm);
        compare_field("electric_drive", want.electric_drive, seen.electric_drive);
        compare_field("engine_drive", want.engine_drive, seen.engine_drive);
        compare_field("stage", want.stage, seen.stage);
        compare_field("changed", want.changed, seen.changed);
      end
    end
  end

  // The watchdog ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit      y;
    report_t r;
    report_t typed;
    int      start;

    known_keys[0] = with_pwm("electric_motor");
    known_keys[1] = "ice_pwm";
    known_keys[2] = "ICE_pwm";
    known_keys[3] = with_pwm("combustion_engine");
    known_keys[4] = with_pwm("internal_combustion_engine");

    inv_electric = 1'b0;
    inv_engine = 1'b0;
    level_electric = '0;
    level_engine = '0;
    stage_q = '0;
    clear_line();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script, run with the registers as they come out of reset.
    foreach (script[i]) begin
      if (script[i].is_ir) begin
        offer(1'b1, script[i].code, y, r);
      end else begin
        for (int k = 0; k < script[i].text.len(); k++)
          offer(1'b0, {script[i].hi, script[i].text[k]}, y, r);
      end
      if (script[i].typed) begin
        if (script[i].yields) begin
          typed.action = script[i].action;
          typed.electric_pwm = script[i].electric_pwm;
          typed.engine_pwm = script[i].engine_pwm;
          typed.electric_drive = drive_of(script[i].electric_pwm, inv_electric);
          typed.engine_drive = drive_of(script[i].engine_pwm, inv_engine);
          typed.stage = script[i].stage;
          typed.changed = script[i].changed;
          awaited_reports.push_back(typed);
        end
      end else if (y) begin
        awaited_reports.push_back(r);
      end
    end

    // Random phases. Each one sets both inversion bits to a new combination and its
    // own idling: none, the sender idle about half the time, the receiver stalling
    // about half the time, and both a little.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct = 49; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct <= 49; end
        default: begin tx_idle_pct = 15; rx_stall_pct <= 15; end
      endcase
      cfg_write(REG_ELECTRIC_INV, {31'd0, ph[0]});
      cfg_write(REG_ENGINE_INV, {31'd0, ph[1]});
      start = items_sent;
      if (ph == 0) begin
        // Stage commands keep coming while the receiver holds off.
        hold_req <= ~hold_req;
        repeat (24) offer_checked(1'b1, IR_NUMBER_CODE[$urandom_range(0, NUM_STAGE_CODES - 1)]);
        // The longest line that is still parsed.
        compose_long(KEPT_MAX);
        send_line();
      end
      if (ph == 2) begin
        // One byte too many: the whole line is thrown away.
        compose_long(LINE_LIMIT);
        send_line();
      end
      while (items_sent - start < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            compose_line();
            send_line();
          end
          12, 13, 14, 15, 16: offer_checked(1'b1, ir_pick());
          default: repeat ($urandom_range(1, 6)) send_serial(8'($urandom_range(0, 255)));
        endcase
      end
    end

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/mcfe_pkg.sv
rtl/core/mcfe_ir_decoder.sv
rtl/core/mcfe_serial_parser.sv
rtl/core/motor_command_front_end_top.sv
test/tb_motor_command_front_end_top.sv
